/* sv/assert_macros.svh */
// Assertion macros shared by the execute unit RTL.
// Needs signals named clock and reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EXU_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("execute unit: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define EXU_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("execute unit: next-cycle check failed");

`endif

/* sv/exu_pkg.sv */
// Shared types, opcode and register codes and flag positions of the execute unit.
// No dependencies; used by the channel interfaces and the top level.
package exu_pkg;

   localparam int MEM_BYTES_DEFAULT = 65536;
   localparam int GPR_COUNT         = 8;
   localparam int GPR_IDX_W         = 3;

   typedef logic [3:0]  opcode_type;
   typedef logic [3:0]  reg_sel_type;
   typedef logic [3:0]  base_sel_type;
   typedef logic [1:0]  src_kind_type;
   typedef logic [2:0]  length_type;
   typedef logic [15:0] word_type;
   typedef logic [7:0]  byte_type;

   // opcodes
   localparam opcode_type OP_MOV    = 4'd0;
   localparam opcode_type OP_ADD    = 4'd1;
   localparam opcode_type OP_SUB    = 4'd2;
   localparam opcode_type OP_CMP    = 4'd3;
   localparam opcode_type OP_JZ     = 4'd4;
   localparam opcode_type OP_JNZ    = 4'd5;
   localparam opcode_type OP_JP     = 4'd6;
   localparam opcode_type OP_JB     = 4'd7;
   localparam opcode_type OP_LOOPNZ = 4'd8;

   // register indexes
   localparam reg_sel_type REG_BX    = 4'd1;
   localparam reg_sel_type REG_CX    = 4'd2;
   localparam reg_sel_type REG_BP    = 4'd5;
   localparam reg_sel_type REG_SI    = 4'd6;
   localparam reg_sel_type REG_DI    = 4'd7;
   localparam reg_sel_type REG_IP    = 4'd8;
   localparam reg_sel_type REG_FLAGS = 4'd9;

   // operand kinds
   localparam logic         DEST_REG = 1'b0;
   localparam logic         DEST_MEM = 1'b1;
   localparam src_kind_type SRC_REG  = 2'd0;
   localparam src_kind_type SRC_IMM  = 2'd1;
   localparam src_kind_type SRC_MEM  = 2'd2;

   // address base codes
   localparam base_sel_type BASE_BP    = 4'd1;
   localparam base_sel_type BASE_BP_DI = 4'd2;
   localparam base_sel_type BASE_BP_SI = 4'd3;
   localparam base_sel_type BASE_BX    = 4'd4;
   localparam base_sel_type BASE_BX_DI = 4'd5;
   localparam base_sel_type BASE_BX_SI = 4'd6;
   localparam base_sel_type BASE_DI    = 4'd7;
   localparam base_sel_type BASE_SI    = 4'd8;

   // flag bit positions
   localparam int FLAG_CF = 0;
   localparam int FLAG_PF = 2;
   localparam int FLAG_AF = 4;
   localparam int FLAG_ZF = 6;
   localparam int FLAG_SF = 7;
   localparam int FLAG_OF = 11;
   localparam word_type ARITH_FLAGS_MASK = 16'h08D5;

   // even parity of a byte
   function automatic logic parity_even(input byte_type v);
      return ~^v;
   endfunction

endpackage

/* sv/exu_if.sv */
// Request and response channel interfaces of the execute unit.
// Depends on exu_pkg for the payload types.
interface exu_req_if;
   import exu_pkg::*;

   logic         valid;
   logic         ready;
   opcode_type   req_type;
   logic         is_word;
   logic         dest_kind;
   reg_sel_type  dest_reg;
   logic         dest_high_byte;
   src_kind_type src_kind;
   reg_sel_type  src_reg;
   logic         src_high_byte;
   base_sel_type addr_base;
   word_type     displacement;
   word_type     immediate;
   length_type   instr_length;

   modport source (
      output valid, req_type, is_word, dest_kind, dest_reg, dest_high_byte,
             src_kind, src_reg, src_high_byte, addr_base, displacement,
             immediate, instr_length,
      input  ready
   );
   modport sink (
      input  valid, req_type, is_word, dest_kind, dest_reg, dest_high_byte,
             src_kind, src_reg, src_high_byte, addr_base, displacement,
             immediate, instr_length,
      output ready
   );
endinterface

interface exu_rsp_if;
   import exu_pkg::*;

   logic     valid;
   logic     ready;
   logic     accepted;
   word_type result_value;
   word_type flags_after;
   word_type pointer_after;

   modport source (
      output valid, accepted, result_value, flags_after, pointer_after,
      input  ready
   );
   modport sink (
      input  valid, accepted, result_value, flags_after, pointer_after,
      output ready
   );
endinterface

/* sv/exu_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module exu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* sv/sixteen_bit_cpu_execute_unit.sv */
// Execute unit for a 16-bit processor subset: each request is one decoded mov, add, sub,
// cmp or conditional jump, executed against eight general registers kept in a synchronous
// RAM (two copies for two read ports), IP and FLAGS in flip-flops, and a byte memory of
// MEM_BYTES bytes (a power of two) split into even and odd banks so a word access, also
// one that wraps from the top of memory to address 0, reads or writes both its bytes at
// once. A request passes through the accept cycle, which reads the address base registers,
// the address state, which forms the effective address and reads the operands, and the
// execute state, which computes and writes back; the two dependent synchronous reads
// (register file, then memory) set this order. A response waiting on rsp_chan stalls only
// the write-back cycle. After reset the unit zero-fills both banks before its first request.
// Depends on exu_pkg, exu_if, exu_ram and assert_macros.svh.
`include "assert_macros.svh"

module sixteen_bit_cpu_execute_unit #(
   parameter int MEM_BYTES = exu_pkg::MEM_BYTES_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   exu_req_if.sink    req_chan,
   exu_rsp_if.source  rsp_chan
);
   import exu_pkg::*;

   localparam int ADDR_W     = $clog2(MEM_BYTES);
   localparam int BANK_W     = ADDR_W - 1;
   localparam int BANK_DEPTH = MEM_BYTES / 2;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EA    = 2'd2;
   localparam logic [1:0] ST_EXEC  = 2'd3;

   typedef struct packed {
      logic                 use_a;
      logic                 use_b;
      logic [GPR_IDX_W-1:0] reg_a;
      logic [GPR_IDX_W-1:0] reg_b;
   } base_regs_type;

   // which registers a base code adds
   function automatic base_regs_type base_decode(input base_sel_type code);
      base_regs_type r;
      r = '0;
      case (code) inside
         BASE_BP, BASE_BP_DI, BASE_BP_SI: begin
            r.use_a = 1'b1;
            r.reg_a = REG_BP[GPR_IDX_W-1:0];
         end
         BASE_BX, BASE_BX_DI, BASE_BX_SI: begin
            r.use_a = 1'b1;
            r.reg_a = REG_BX[GPR_IDX_W-1:0];
         end
         BASE_DI: begin
            r.use_a = 1'b1;
            r.reg_a = REG_DI[GPR_IDX_W-1:0];
         end
         BASE_SI: begin
            r.use_a = 1'b1;
            r.reg_a = REG_SI[GPR_IDX_W-1:0];
         end
         default: r.use_a = 1'b0;
      endcase
      case (code) inside
         BASE_BP_DI, BASE_BX_DI: begin
            r.use_b = 1'b1;
            r.reg_b = REG_DI[GPR_IDX_W-1:0];
         end
         BASE_BP_SI, BASE_BX_SI: begin
            r.use_b = 1'b1;
            r.reg_b = REG_SI[GPR_IDX_W-1:0];
         end
         default: r.use_b = 1'b0;
      endcase
      return r;
   endfunction

   // full 16-bit view of a register index
   function automatic word_type reg_view(input reg_sel_type sel, input word_type gpr,
                                         input word_type ip, input word_type flags);
      word_type v;
      v = '0;
      if (sel[3] == 1'b0) begin
         v = gpr;
      end else if (sel == REG_IP) begin
         v = ip;
      end else if (sel == REG_FLAGS) begin
         v = flags;
      end
      return v;
   endfunction

   // byte or word operand from a register value
   function automatic word_type operand_view(input word_type v, input logic word,
                                             input logic high);
      word_type r;
      if (word) begin
         r = v;
      end else if (high) begin
         r = {8'h00, v[15:8]};
      end else begin
         r = {8'h00, v[7:0]};
      end
      return r;
   endfunction

   // control and latched request
   logic [1:0]          state_ff, state_in;
   logic [BANK_W-1:0]   clr_idx_ff, clr_idx_in;
   opcode_type          op_ff;
   logic                word_ff, dkind_ff, dhigh_ff, shigh_ff;
   reg_sel_type         dreg_ff, sreg_ff;
   src_kind_type        skind_ff;
   base_sel_type        base_ff;
   word_type            disp_ff, imm_ff;
   length_type          len_ff;
   logic [ADDR_W-1:0]   ea_ff;
   logic [GPR_COUNT-1:0] gpr_valid_ff, gpr_valid_in;
   logic                va_ff, vb_ff;
   word_type            ip_ff, ip_in;
   word_type            flags_ff, flags_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_accepted_ff;
   word_type            rsp_result_ff, rsp_flags_ff, rsp_pointer_ff;

   logic                req_accept, exec_go;

   // register file ports
   logic [GPR_IDX_W-1:0] rf_a_addr, rf_b_addr, gpr_wr_addr;
   word_type             rf_a_data, rf_b_data, gpr_wr_data, gpr_a, gpr_b;
   logic                 gpr_we;
   base_regs_type        base_req, base_lat;

   // memory bank ports
   logic [ADDR_W-1:0]    mem_addr;
   word_type             ea_sum;
   logic [BANK_W-1:0]    bank_idx, b0_addr, b1_addr;
   logic                 odd;
   byte_type             b0_rd, b1_rd, b0_wr, b1_wr, mem_lo, mem_hi;
   logic                 b0_we, b1_we, mem_we, clearing;

   // execute datapath
   word_type             src_full, dst_full, mem_val, s_val, d_val, mask, sign;
   logic [16:0]          sum17, diff17;
   word_type             result, merged, flags_wr, ip_wr, cx_dec, jump_target;
   logic                 cf, of, taken, writes_dest, reg_dest, arith_op;

   assign req_accept = req_chan.valid && req_chan.ready;
   assign exec_go    = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_chan.ready);
   assign clearing   = (state_ff == ST_CLEAR);

   // register file read addresses: base registers at accept, operands after
   assign base_req = base_decode(req_chan.addr_base);
   assign base_lat = base_decode(base_ff);

   always_comb begin
      rf_a_addr = sreg_ff[GPR_IDX_W-1:0];
      rf_b_addr = (op_ff == OP_LOOPNZ) ? REG_CX[GPR_IDX_W-1:0] : dreg_ff[GPR_IDX_W-1:0];
      if (state_ff == ST_IDLE) begin
         rf_a_addr = base_req.reg_a;
         rf_b_addr = base_req.reg_b;
      end
   end

   exu_ram #(.WIDTH(16), .DEPTH(GPR_COUNT)) u_rf_a (
      .clock   (clock),
      .wr_en   (gpr_we),
      .wr_addr (gpr_wr_addr),
      .wr_data (gpr_wr_data),
      .rd_addr (rf_a_addr),
      .rd_data (rf_a_data)
   );

   exu_ram #(.WIDTH(16), .DEPTH(GPR_COUNT)) u_rf_b (
      .clock   (clock),
      .wr_en   (gpr_we),
      .wr_addr (gpr_wr_addr),
      .wr_data (gpr_wr_data),
      .rd_addr (rf_b_addr),
      .rd_data (rf_b_data)
   );

   // never-written registers read as zero
   assign gpr_a = va_ff ? rf_a_data : 16'h0000;
   assign gpr_b = vb_ff ? rf_b_data : 16'h0000;

   // effective address, formed in the address cycle
   assign ea_sum = (base_lat.use_a ? gpr_a : 16'h0000)
                 + (base_lat.use_b ? gpr_b : 16'h0000)
                 + disp_ff;

   assign mem_addr = (state_ff == ST_EA) ? ea_sum[ADDR_W-1:0] : ea_ff;
   assign odd      = mem_addr[0];
   assign bank_idx = mem_addr[ADDR_W-1:1];

   // bank addresses: the even byte of an odd word is in the next row
   always_comb begin
      b0_addr = odd ? bank_idx + {{(BANK_W-1){1'b0}}, 1'b1} : bank_idx;
      b1_addr = bank_idx;
      if (clearing) begin
         b0_addr = clr_idx_ff;
         b1_addr = clr_idx_ff;
      end
   end

   exu_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_mem_even (
      .clock   (clock),
      .wr_en   (b0_we),
      .wr_addr (b0_addr),
      .wr_data (b0_wr),
      .rd_addr (b0_addr),
      .rd_data (b0_rd)
   );

   exu_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_mem_odd (
      .clock   (clock),
      .wr_en   (b1_we),
      .wr_addr (b1_addr),
      .wr_data (b1_wr),
      .rd_addr (b1_addr),
      .rd_data (b1_rd)
   );

   assign mem_lo  = odd ? b1_rd : b0_rd;
   assign mem_hi  = odd ? b0_rd : b1_rd;
   assign mem_val = word_ff ? {mem_hi, mem_lo} : {8'h00, mem_lo};

   // operands
   assign src_full = reg_view(sreg_ff, gpr_a, ip_ff, flags_ff);
   assign dst_full = reg_view(dreg_ff, gpr_b, ip_ff, flags_ff);
   assign mask     = word_ff ? 16'hFFFF : 16'h00FF;
   assign sign     = word_ff ? 16'h8000 : 16'h0080;

   always_comb begin
      case (skind_ff)
         SRC_REG: s_val = operand_view(src_full, word_ff, shigh_ff);
         SRC_IMM: s_val = imm_ff & mask;
         SRC_MEM: s_val = mem_val;
         default: s_val = 16'h0000;
      endcase
   end

   assign d_val  = (dkind_ff == DEST_MEM) ? mem_val : operand_view(dst_full, word_ff, dhigh_ff);
   assign sum17  = {1'b0, d_val} + {1'b0, s_val};
   assign diff17 = {1'b0, d_val} - {1'b0, s_val};

   // ALU result, carry and overflow
   always_comb begin
      result = 16'h0000;
      cf     = 1'b0;
      of     = 1'b0;
      case (op_ff) inside
         OP_MOV: result = s_val;
         OP_ADD: begin
            result = sum17[15:0] & mask;
            cf     = word_ff ? sum17[16] : sum17[8];
            of     = (((d_val ^ result) & (s_val ^ result)) & sign) != 16'h0000;
         end
         OP_SUB, OP_CMP: begin
            result = diff17[15:0] & mask;
            cf     = diff17[16];
            of     = (((d_val ^ s_val) & (d_val ^ result)) & sign) != 16'h0000;
         end
         default: result = 16'h0000;
      endcase
   end

   assign writes_dest = (op_ff == OP_MOV) || (op_ff == OP_ADD) || (op_ff == OP_SUB);
   assign arith_op    = (op_ff == OP_ADD) || (op_ff == OP_SUB) || (op_ff == OP_CMP);
   assign reg_dest    = writes_dest && (dkind_ff == DEST_REG);

   // destination register value after a byte or word write
   always_comb begin
      if (word_ff) begin
         merged = result;
      end else if (dhigh_ff) begin
         merged = {result[7:0], dst_full[7:0]};
      end else begin
         merged = {dst_full[15:8], result[7:0]};
      end
   end

   // flags: destination write first, then the arithmetic bits
   assign flags_wr = (reg_dest && dreg_ff == REG_FLAGS) ? merged : flags_ff;
   always_comb begin
      flags_in = flags_wr;
      if (arith_op) begin
         flags_in          = flags_wr & ~ARITH_FLAGS_MASK;
         flags_in[FLAG_CF] = cf;
         flags_in[FLAG_PF] = parity_even(result[7:0]);
         flags_in[FLAG_ZF] = (result == 16'h0000);
         flags_in[FLAG_SF] = (result & sign) != 16'h0000;
         flags_in[FLAG_OF] = of;
      end
   end

   // jumps; port B holds CX for loopnz
   assign cx_dec      = gpr_b - 16'h0001;
   assign jump_target = ip_ff + imm_ff - word_type'(len_ff);

   always_comb begin
      case (op_ff)
         OP_JZ:     taken = flags_ff[FLAG_ZF];
         OP_JNZ:    taken = !flags_ff[FLAG_ZF];
         OP_JP:     taken = flags_ff[FLAG_PF];
         OP_JB:     taken = flags_ff[FLAG_CF];
         OP_LOOPNZ: taken = (cx_dec != 16'h0000) && !flags_ff[FLAG_ZF];
         default:   taken = 1'b0;
      endcase
   end

   assign ip_wr = (reg_dest && dreg_ff == REG_IP) ? merged : ip_ff;
   assign ip_in = taken ? jump_target : ip_wr;

   // general register write-back
   assign gpr_we      = exec_go && ((reg_dest && !dreg_ff[3]) || (op_ff == OP_LOOPNZ));
   assign gpr_wr_addr = (op_ff == OP_LOOPNZ) ? REG_CX[GPR_IDX_W-1:0]
                                             : dreg_ff[GPR_IDX_W-1:0];
   assign gpr_wr_data = (op_ff == OP_LOOPNZ) ? cx_dec : merged;

   always_comb begin
      gpr_valid_in = gpr_valid_ff;
      if (gpr_we) begin
         gpr_valid_in[gpr_wr_addr] = 1'b1;
      end
   end

   // memory write-back, or zero fill during the clearing pass
   assign mem_we = exec_go && writes_dest && (dkind_ff == DEST_MEM);
   assign b0_we  = clearing || (mem_we && (word_ff || !odd));
   assign b1_we  = clearing || (mem_we && (word_ff || odd));
   assign b0_wr  = clearing ? 8'h00 : (odd ? result[15:8] : result[7:0]);
   assign b1_wr  = clearing ? 8'h00 : (odd ? result[7:0] : result[15:8]);

   // sequencer
   always_comb begin
      state_in   = state_ff;
      clr_idx_in = clr_idx_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_idx_in = clr_idx_ff + {{(BANK_W-1){1'b0}}, 1'b1};
            if (clr_idx_ff == {BANK_W{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EA;
            end
         end
         ST_EA: state_in = ST_EXEC;
         ST_EXEC: begin
            if (exec_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   assign rsp_valid_in = exec_go ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         gpr_valid_ff <= '0;
         ip_ff        <= 16'h0000;
         flags_ff     <= 16'h0000;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         gpr_valid_ff <= gpr_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exec_go) begin
            ip_ff    <= ip_in;
            flags_ff <= flags_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      va_ff <= gpr_valid_ff[rf_a_addr];
      vb_ff <= gpr_valid_ff[rf_b_addr];
      if (req_accept) begin
         op_ff    <= req_chan.req_type;
         word_ff  <= req_chan.is_word;
         dkind_ff <= req_chan.dest_kind;
         dreg_ff  <= req_chan.dest_reg;
         dhigh_ff <= req_chan.dest_high_byte;
         skind_ff <= req_chan.src_kind;
         sreg_ff  <= req_chan.src_reg;
         shigh_ff <= req_chan.src_high_byte;
         base_ff  <= req_chan.addr_base;
         disp_ff  <= req_chan.displacement;
         imm_ff   <= req_chan.immediate;
         len_ff   <= req_chan.instr_length;
      end
      if (state_ff == ST_EA) begin
         ea_ff <= ea_sum[ADDR_W-1:0];
      end
      if (exec_go) begin
         rsp_accepted_ff <= (op_ff <= OP_LOOPNZ);
         rsp_result_ff   <= result;
         rsp_flags_ff    <= flags_in;
         rsp_pointer_ff  <= ip_in;
      end
   end

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.accepted      = rsp_accepted_ff;
   assign rsp_chan.result_value  = rsp_result_ff;
   assign rsp_chan.flags_after   = rsp_flags_ff;
   assign rsp_chan.pointer_after = rsp_pointer_ff;

   // checks
   `EXU_ASSERT_NEXT(a_accept_to_addr, req_accept, state_ff == ST_EA)
   `EXU_ASSERT_NEXT(a_commit_to_rsp, exec_go, rsp_valid_ff && state_ff == ST_IDLE)
   `EXU_ASSERT_SAME(a_mem_write_when, b0_we || b1_we, clearing || exec_go)
   `EXU_ASSERT_SAME(a_gpr_write_when, gpr_we, state_ff == ST_EXEC && exec_go)

endmodule
